// ===== hdl/sida_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII converter.
// Used by sida_ctrl, sida_datapath and the top level; depends on nothing.
`default_nettype none

package sida_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned CHAR_W  = 7;
   localparam int unsigned DIGIT_W = 4;
   localparam int unsigned POWER_W = 4;
   localparam int unsigned WEIGHT_W = 34;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0]  CHAR_NINE  = 7'h39;
   localparam logic [POWER_W-1:0] TOP_POWER  = 4'd9;
   localparam logic [DIGIT_W-1:0] MAX_DIGIT  = 4'd9;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic wr_sign;
      logic step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_negative;
      logic emit;
      logic final_digit;
   } sts_type;

   // Digit d times ten to the power k, wide enough for 9 * 10^9.
   function automatic logic [WEIGHT_W-1:0] digit_weight(input logic [POWER_W-1:0] k,
                                                        input logic [DIGIT_W-1:0] d);
      logic [WEIGHT_W-1:0] base;
      case (k)
         4'd0: base = 34'd1;
         4'd1: base = 34'd10;
         4'd2: base = 34'd100;
         4'd3: base = 34'd1000;
         4'd4: base = 34'd10000;
         4'd5: base = 34'd100000;
         4'd6: base = 34'd1000000;
         4'd7: base = 34'd10000000;
         4'd8: base = 34'd100000000;
         4'd9: base = 34'd1000000000;
         default: base = 34'd1;
      endcase
      return WEIGHT_W'(base * {{(WEIGHT_W-DIGIT_W){1'b0}}, d});
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sida_datapath.sv =====
// Datapath: magnitude remainder, power-of-ten counter and result payload register.
// Depends on sida_pkg; driven by sida_ctrl through sida_pkg::cmd_type.
`default_nettype none

module sida_datapath (
   input  wire logic                              clock,
   input  wire logic [sida_pkg::VALUE_W-1:0]      req_value,
   input  wire sida_pkg::cmd_type                 cmd,
   output sida_pkg::sts_type                      sts,
   output logic [sida_pkg::CHAR_W-1:0]            rsp_character,
   output logic                                   rsp_last
);

   logic [sida_pkg::VALUE_W-1:0] rem_ff, rem_in;
   logic [sida_pkg::POWER_W-1:0] k_ff, k_in;
   logic                         started_ff, started_in;
   logic [sida_pkg::CHAR_W-1:0]  char_ff, char_in;
   logic                         last_ff, last_in;

   logic [sida_pkg::DIGIT_W-1:0]  digit;
   logic [sida_pkg::WEIGHT_W-1:0] weight;
   logic [sida_pkg::VALUE_W-1:0]  magnitude;
   logic                          emit;

   // Two's complement negate also covers the most negative value in 32 bits.
   assign magnitude = req_value[sida_pkg::VALUE_W-1] ? (~req_value + 32'd1) : req_value;

   // The current digit is the largest multiple of 10^k that fits in the remainder.
   always_comb begin
      digit  = '0;
      weight = '0;
      for (int d = 1; d <= int'(sida_pkg::MAX_DIGIT); d++) begin
         if ({2'b00, rem_ff} >= sida_pkg::digit_weight(k_ff, sida_pkg::DIGIT_W'(d))) begin
            digit  = sida_pkg::DIGIT_W'(d);
            weight = sida_pkg::digit_weight(k_ff, sida_pkg::DIGIT_W'(d));
         end
      end
   end

   // Leading zeros are dropped, but the units digit always goes out.
   assign emit = started_ff || (digit != '0) || (k_ff == '0);

   assign sts.in_negative = req_value[sida_pkg::VALUE_W-1];
   assign sts.emit        = emit;
   assign sts.final_digit = (k_ff == '0);

   always_comb begin
      rem_in     = rem_ff;
      k_in       = k_ff;
      started_in = started_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      if (cmd.load) begin
         rem_in     = magnitude;
         k_in       = sida_pkg::TOP_POWER;
         started_in = 1'b0;
      end else if (cmd.wr_sign) begin
         char_in = sida_pkg::CHAR_MINUS;
         last_in = 1'b0;
      end else if (cmd.step) begin
         rem_in     = rem_ff - weight[sida_pkg::VALUE_W-1:0];
         k_in       = k_ff - 4'd1;
         started_in = emit;
         if (emit) begin
            char_in = sida_pkg::CHAR_ZERO + {3'b000, digit};
            last_in = (k_ff == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      k_ff       <= k_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

// ===== hdl/sida_ctrl.sv =====
// Controller: sequences sign and digit steps and owns the result valid flag.
// Depends on sida_pkg; commands sida_datapath through sida_pkg::cmd_type.
`default_nettype none

module sida_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire sida_pkg::sts_type  sts,
   output sida_pkg::cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new character if empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.in_negative ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               cmd.wr_sign = 1'b1;
               state_in    = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            // A leading zero is skipped without waiting for the result register.
            if (out_free || !sts.emit) begin
               cmd.step = 1'b1;
               if (sts.final_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.wr_sign || (cmd.step && sts.emit)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII, one character per result transaction.
// An item goes through a load step, a minus sign step when negative, then one digit step
// per power of ten from 10^9 down to 10^0; a full result register stalls the sign step and
// each emitting digit step. The ten digit steps share one compare-and-subtract unit, and a
// new value is accepted only in the idle state, after the units digit step. Leading zeros
// are skipped without a character. Synchronous reset clears the controller state and the
// result valid flag.
`default_nettype none

module signed_int_to_decimal_ascii (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [sida_pkg::VALUE_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [sida_pkg::CHAR_W-1:0]         rsp_character,
   output logic                                rsp_last
);

   sida_pkg::cmd_type cmd;
   sida_pkg::sts_type sts;

   sida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sida_datapath u_datapath (
      .clock         (clock),
      .req_value     (req_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // Once a transaction is taken, the block is busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted on two consecutive cycles");

   // A load always starts the digit count at the highest power of ten.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !sts.final_digit)
      else $error("digit counter not reloaded");

   // Only a minus sign or a decimal digit ever leaves the block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_character == sida_pkg::CHAR_MINUS) ||
                     ((rsp_character >= sida_pkg::CHAR_ZERO) &&
                      (rsp_character <= sida_pkg::CHAR_NINE))))
      else $error("illegal output character");

endmodule

`default_nettype wire

// ===== tb/tb_signed_int_to_decimal_ascii.sv =====
// Self-checking testbench for signed_int_to_decimal_ascii: drives signed integers and
// checks every ASCII character and the last flag of each decimal text against its own model.
// Depends on sida_pkg for the port widths and the character codes.

module tb_signed_int_to_decimal_ascii;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [sida_pkg::CHAR_W-1:0] ch;
      logic                        last;
   } text_char_type;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [sida_pkg::VALUE_W-1:0]  req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [sida_pkg::CHAR_W-1:0]   rsp_character;
   logic                          rsp_last;

   text_char_type pending_chars[$];
   bit            failed = 1'b0;
   int            ready_hold = 0;
   bit            ready_level = 1'b0;

   signed_int_to_decimal_ascii uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always #5 clock = ~clock;

   // Decimal text of a two's complement value, most significant character first.
   // Negating the most negative value wraps to 2^31, which is its true magnitude.
   function automatic void queue_decimal_text(input logic [sida_pkg::VALUE_W-1:0] value);
      logic [sida_pkg::VALUE_W-1:0] mag;
      logic [3:0]                   digits[10];
      int                           count;
      text_char_type                entry;
      mag   = value[sida_pkg::VALUE_W-1] ? sida_pkg::VALUE_W'(-value) : value;
      count = 0;
      do begin
         digits[count] = 4'(mag % 10);
         mag           = mag / 10;
         count++;
      end while (mag != 0 && count < 10);
      if (value[sida_pkg::VALUE_W-1]) begin
         entry.ch   = sida_pkg::CHAR_MINUS;
         entry.last = 1'b0;
         pending_chars.push_back(entry);
      end
      for (int k = count - 1; k >= 0; k--) begin
         entry.ch   = sida_pkg::CHAR_ZERO + sida_pkg::CHAR_W'(digits[k]);
         entry.last = (k == 0);
         pending_chars.push_back(entry);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(15, 4);
      return $urandom_range(60, 16);
   endfunction

   // Called at a rising edge; returns at the edge where the transaction is accepted.
   task automatic send_value(input logic [sida_pkg::VALUE_W-1:0] value, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      queue_decimal_text(value);
   endtask

   task automatic wait_text_drained();
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Value with exactly the given number of decimal digits and a random sign.
   function automatic logic [sida_pkg::VALUE_W-1:0] value_of_length(input int ndigits);
      longint                       lo, hi;
      bit                           neg;
      logic [sida_pkg::VALUE_W-1:0] mag;
      neg = $urandom_range(1, 0);
      lo  = 1;
      for (int i = 1; i < ndigits; i++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (neg && hi > 64'd2147483648) hi = 64'd2147483648;
      if (!neg && hi > 64'd2147483647) hi = 64'd2147483647;
      mag = $urandom_range(32'(hi), 32'(lo));
      return neg ? sida_pkg::VALUE_W'(-mag) : mag;
   endfunction

   task automatic test_directed_values();
      logic [sida_pkg::VALUE_W-1:0] values[$];
      values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'd1000000000,
                 32'd999999999, 32'd1000000009, -32'sd1000000000, 32'd123456789,
                 -32'sd987654321, 32'h0000FFFF, 32'hAAAAAAAA, 32'h55555555,
                 32'd2147483640, -32'sd9, 32'd1000000};
      foreach (values[i]) send_value(values[i], 1'b0);
   endtask

   // Full range values; every so often the sender holds off until all text is out.
   task automatic test_random_values(input int count);
      for (int i = 0; i < count; i++) begin
         send_value($urandom(), 1'b0);
         if (i % 60 == 59) wait_text_drained();
      end
   endtask

   task automatic test_digit_counts(input int count);
      for (int i = 0; i < count; i++)
         send_value(value_of_length($urandom_range(10, 1)), 1'b0);
   endtask

   // The sender never idles here, so loads follow the last character directly.
   task automatic test_back_to_back(input int count);
      for (int i = 0; i < count; i++)
         send_value(value_of_length($urandom_range(10, 1)), 1'b1);
   endtask

   // The receiver mixes short and long stalls with long stretches of steady readiness.
   always @(posedge clock) begin
      int r;
      if (ready_hold == 0) begin
         r = $urandom_range(9, 0);
         if (r < 5) begin
            ready_level = 1'b1;
            ready_hold  = $urandom_range(20, 1);
         end else if (r < 8) begin
            ready_level = 1'b0;
            ready_hold  = $urandom_range(3, 1);
         end else if (r < 9) begin
            ready_level = 1'b0;
            ready_hold  = $urandom_range(30, 4);
         end else begin
            ready_level = 1'b1;
            ready_hold  = $urandom_range(200, 50);
         end
      end
      ready_hold--;
      rsp_ready <= ready_level;
   end

   always @(posedge clock) begin : check_text
      text_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected transaction: character %0d last %0d", rsp_character, rsp_last);
            failed = 1'b1;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_character !== want.ch) begin
               $error("character: expected %0d, actual %0d", want.ch, rsp_character);
               failed = 1'b1;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_values();
      test_random_values(220);
      test_digit_counts(200);
      test_back_to_back(60);
      wait_text_drained();
      repeat (40) @(posedge clock);
      if (!failed && pending_chars.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/sida_pkg.sv
hdl/sida_datapath.sv
hdl/sida_ctrl.sv
hdl/signed_int_to_decimal_ascii.sv
tb/tb_signed_int_to_decimal_ascii.sv
